### rtl/core/cfir_pkg.sv
// Shared types and constants for the centred Q16 FIR filter.
`timescale 1ns / 1ps

package cfir_pkg;

  localparam int SampleW     = 16;
  localparam int AccW        = 32;
  localparam int NumTapRegs  = 16;
  localparam int TapsPerReg  = 4;
  localparam int NumTapWords = NumTapRegs / TapsPerReg;
  localparam int TapWordIdxW = $clog2(NumTapWords);
  localparam int CfgDataW    = 64;
  localparam int CfgIdxW     = 3;
  localparam int TapCountW   = 5;
  localparam int ResultShift = 16;

  localparam logic [AccW-1:0]      RoundConst    = AccW'(32'h8000);
  localparam logic [TapCountW-1:0] TapCountReset = TapCountW'(1);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgTaps0    = 3'd0,
    CfgTaps1    = 3'd1,
    CfgTaps2    = 3'd2,
    CfgTaps3    = 3'd3,
    CfgTapCount = 3'd4
  } cfg_reg_e;

  // One 16-bit value per tap lane, lane 0 in the low bits
  typedef logic [NumTapRegs-1:0][SampleW-1:0] lane_vec_t;

  // Aligned sample window waiting for the multiply-add pipeline
  typedef struct packed {
    lane_vec_t win;
    logic      last;
  } win_item_t;

endpackage

### rtl/core/cfir_sample_if.sv
// Input channel carrying one sample item.
`timescale 1ns / 1ps

interface cfir_sample_if;
  import cfir_pkg::*;

  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;
  logic               sample_is_last;

  modport source (output valid, output sample, output sample_is_last, input ready);
  modport sink   (input valid, input sample, input sample_is_last, output ready);
endinterface

### rtl/core/cfir_result_if.sv
// Output channel carrying one filtered result item.
`timescale 1ns / 1ps

interface cfir_result_if;
  import cfir_pkg::*;

  logic               valid;
  logic               ready;
  logic [SampleW-1:0] filtered;
  logic               result_is_last;

  modport source (output valid, output filtered, output result_is_last, input ready);
  modport sink   (input valid, input filtered, input result_is_last, output ready);
endinterface

### rtl/core/cfir_front.sv
// Front end: accepts samples, shifts the delay line and builds the centred window.
`timescale 1ns / 1ps

module cfir_front #(
  parameter int LineDepth = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cfir_sample_if.sink                   sample_ch_i,
  input  logic [cfir_pkg::TapCountW-1:0] tap_count_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output cfir_pkg::win_item_t           push_item_o
);
  import cfir_pkg::*;

  localparam int IdxW = (LineDepth > 1) ? $clog2(LineDepth) : 1;

  logic [SampleW-1:0]   dl_q   [LineDepth];
  logic [SampleW-1:0]   dl_new [LineDepth];
  logic [TapCountW-1:0] kc;
  logic [TapCountW-1:0] sel    [NumTapRegs];
  logic                 accept;

  assign sample_ch_i.ready = push_ready_i;
  assign accept            = sample_ch_i.valid & push_ready_i;
  assign push_valid_o      = sample_ch_i.valid;

  // Delay line as it stands once the new sample is in
  always_comb begin
    dl_new[0] = sample_ch_i.sample;
    for (int j = 1; j < LineDepth; j++) begin
      dl_new[j] = dl_q[j-1];
    end
  end

  // Clamp the tap count to the line depth
  assign kc = (tap_count_i > TapCountW'(LineDepth)) ? TapCountW'(LineDepth) : tap_count_i;

  // Lane m takes the sample k-1-m places back; unused lanes read zero
  always_comb begin
    push_item_o.last = sample_ch_i.sample_is_last;
    for (int m = 0; m < NumTapRegs; m++) begin
      sel[m] = kc - TapCountW'(m) - TapCountW'(1);
      if (TapCountW'(m) < kc) begin
        push_item_o.win[m] = dl_new[sel[m][IdxW-1:0]];
      end else begin
        push_item_o.win[m] = '0;
      end
    end
  end

  // Advance the delay line on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < LineDepth; j++) begin
        dl_q[j] <= '0;
      end
    end else if (accept) begin
      for (int j = 0; j < LineDepth; j++) begin
        dl_q[j] <= dl_new[j];
      end
    end
  end

endmodule

### rtl/core/cfir_fifo.sv
// Short queue of sample windows between the front end and the datapath.
`timescale 1ns / 1ps

module cfir_fifo #(
  parameter int Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  cfir_pkg::win_item_t push_item_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output cfir_pkg::win_item_t pop_item_o
);
  import cfir_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  win_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // Pointer and fill count updates
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the item; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue fill count did not rise on push");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers differ while empty");
`endif

endmodule

### rtl/core/cfir_back.sv
// Datapath: tap products, registered adder tree, rounding and output register.
`timescale 1ns / 1ps

module cfir_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfir_pkg::lane_vec_t taps_i,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  cfir_pkg::win_item_t pop_item_i,
  cfir_result_if.source       result_ch_o
);
  import cfir_pkg::*;

  logic                          advance;
  logic                          v1_q, v2_q, out_valid_q;
  logic                          last1_q, last2_q, out_last_q;
  logic [NumTapRegs-1:0][AccW-1:0]  prod_q, prod_d;
  logic [NumTapWords-1:0][AccW-1:0] psum_q, psum_d;
  logic [AccW-1:0]               acc;
  logic [SampleW-1:0]            filtered_q;

  // The whole pipe moves unless a result is waiting on the receiver
  assign advance     = !out_valid_q || result_ch_o.ready;
  assign pop_ready_o = advance;

  // One product per lane, both operands sign-extended to the sum width
  always_comb begin
    for (int m = 0; m < NumTapRegs; m++) begin
      prod_d[m] = AccW'($signed(taps_i[m])) * AccW'($signed(pop_item_i.win[m]));
    end
  end

  // Partial sums over each group of lanes, wrapping at 32 bits
  always_comb begin
    for (int g = 0; g < NumTapWords; g++) begin
      psum_d[g] = '0;
      for (int l = 0; l < TapsPerReg; l++) begin
        psum_d[g] = psum_d[g] + prod_q[g*TapsPerReg + l];
      end
    end
  end

  // Final sum with the rounding constant
  always_comb begin
    acc = RoundConst;
    for (int g = 0; g < NumTapWords; g++) begin
      acc = acc + psum_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      v1_q        <= pop_valid_i;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  // Payload stages; hold while stalled
  always_ff @(posedge clk_i) begin
    if (advance) begin
      prod_q     <= prod_d;
      last1_q    <= pop_item_i.last;
      psum_q     <= psum_d;
      last2_q    <= last1_q;
      filtered_q <= acc[ResultShift +: SampleW];
      out_last_q <= last2_q;
    end
  end

  assign result_ch_o.valid          = out_valid_q;
  assign result_ch_o.filtered       = filtered_q;
  assign result_ch_o.result_is_last = out_last_q;

endmodule

### rtl/core/centered_fir_q16_round.sv
// Top level of the centred 16-bit FIR filter with Q16 rounding.
//
// Channels: sample_ch_i takes one signed 16-bit sample and a row-end mark per
// item; result_ch_o gives one filtered 16-bit result per sample, with the mark
// copied. Both use valid/ready; an item moves when both are high.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (tap
// words 0..3, then the tap count); write only while no item is in flight.
// Each output is the rounded centred correlation over the last k samples, so
// results lag their samples by k-1-k/2 items; flush with zeros at the end.
// Throughput: one item per cycle unless the receiver stalls. Items pass the
// queue, then product, partial-sum and output registers; sixteen parallel
// multipliers feed a two-level adder tree, so every lane works on each item.
// Reset clears the delay line, the queue and the pipeline, sets all taps to
// zero and the tap count to one.
// When the receiver stalls, the datapath holds and the two-entry queue fills
// before sample_ch_i.ready drops; no item is lost.
`timescale 1ns / 1ps

module centered_fir_q16_round #(
  parameter int MAX_TAPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cfir_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cfir_pkg::CfgDataW-1:0] cfg_data_i,
  cfir_sample_if.sink                   sample_ch_i,
  cfir_result_if.source                 result_ch_o
);
  import cfir_pkg::*;

  localparam int LineDepth = (MAX_TAPS < NumTapRegs) ? MAX_TAPS : NumTapRegs;

  logic [NumTapWords-1:0][CfgDataW-1:0] tap_regs_q, tap_regs_d;
  logic [TapCountW-1:0]                 tap_count_q, tap_count_d;
  lane_vec_t                            taps;
  logic                                 push_valid, push_ready;
  logic                                 pop_valid, pop_ready;
  win_item_t                            push_item, pop_item;

  // Decode configuration writes; unknown indexes are dropped
  always_comb begin
    tap_regs_d  = tap_regs_q;
    tap_count_d = tap_count_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i) inside
        CfgTaps0, CfgTaps1, CfgTaps2, CfgTaps3: begin
          tap_regs_d[cfg_idx_i[TapWordIdxW-1:0]] = cfg_data_i;
        end
        CfgTapCount: begin
          tap_count_d = cfg_data_i[TapCountW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_regs_q  <= '0;
      tap_count_q <= TapCountReset;
    end else begin
      tap_regs_q  <= tap_regs_d;
      tap_count_q <= tap_count_d;
    end
  end

  assign taps = lane_vec_t'(tap_regs_q);

  cfir_front #(
    .LineDepth (LineDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_ch_i  (sample_ch_i),
    .tap_count_i  (tap_count_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  cfir_fifo #(
    .Depth (2)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  cfir_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .taps_i      (taps),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .result_ch_o (result_ch_o)
  );

endmodule
